FILE: hdl/ero_pkg.sv
// Shared types and constants for the 3x3 binary erosion block.
package ero_pkg;

	// Configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Default geometry limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DIM_RESET      = 1024;
	localparam int DIM_MIN        = 3;

	// Result field widths
	localparam int POS_W   = 10;
	localparam int COUNT_W = 21;
	localparam logic [COUNT_W-1:0] WHITE_MAX = {COUNT_W{1'b1}};

	// 3x3 window, three columns of three rows, all white
	localparam logic [8:0] WIN_WHITE = 9'h1FF;

	typedef struct packed {
		logic mode;
		logic pixel_in;
	} in_item_t;

	typedef struct packed {
		logic               out_pixel;
		logic [POS_W-1:0]   out_row;
		logic [POS_W-1:0]   out_col;
		logic [COUNT_W-1:0] white_count;
		logic               run_last;
		logic               frame_done;
	} out_item_t;

	// Per-item control handed from the front end to the window stage
	typedef struct packed {
		logic             pix;        // new pixel, padding already applied
		logic             first_col;
		logic             row_ge1;
		logic             row_ge2;
		logic             last_col;
		logic             frame_end;  // last item of the drain row
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} ero_ctl_t;

endpackage

FILE: hdl/ero_linebuf.sv
// Two-row line buffer: one 2-bit-wide memory, registered read, write-back to the read address.
module ero_linebuf #(
	parameter int DEPTH = ero_pkg::DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [1:0]               rd_data,
	input  logic                     wr_en,
	input  logic [1:0]               wr_data
);

	localparam int AW = $clog2(DEPTH);

	// bit 1: row two above, bit 0: row above
	logic [1:0]    mem [DEPTH];
	logic [AW-1:0] addr_s1;

	// Read on accept; remember the address for the write-back
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	// Write-back from the window stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
	end

endmodule

FILE: hdl/ero_front.sv
// Front end: configuration registers, raster counters, input transaction and padding.
module ero_front #(
	parameter int MAX_WIDTH  = ero_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ero_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ero_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ero_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	input  ero_pkg::in_item_t                in_data,
	input  logic                             in_stall,
	output logic                             accept,
	output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
	output ero_pkg::ero_ctl_t                ctl
);

	localparam int CLW  = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int MW   = (WW > HW) ? WW : HW;
	localparam int CW   = ((MW > ero_pkg::CFG_W) ? MW : ero_pkg::CFG_W) + 1;
	localparam int W_RST = (ero_pkg::DIM_RESET < MAX_WIDTH)  ? ero_pkg::DIM_RESET : MAX_WIDTH;
	localparam int H_RST = (ero_pkg::DIM_RESET < MAX_HEIGHT) ? ero_pkg::DIM_RESET : MAX_HEIGHT;

	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [CLW-1:0] col_q;
	logic [HW-1:0]  row_q;
	logic [CW-1:0]  cfg_ext;
	logic [CW-1:0]  w_clamp;
	logic [CW-1:0]  h_clamp;
	logic           drain;
	logic           last_col;

	assign accept  = in_valid && !in_stall;
	assign rd_addr = col_q;

	// Clamp written dimensions into the legal range
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext < CW'(ero_pkg::DIM_MIN)) begin
			w_clamp = CW'(ero_pkg::DIM_MIN);
			h_clamp = CW'(ero_pkg::DIM_MIN);
		end else begin
			w_clamp = (cfg_ext > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : cfg_ext;
			h_clamp = (cfg_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg_ext;
		end
	end

	// Position decode and padding
	assign drain    = row_q >= height_q;
	assign last_col = (CW'(col_q) + CW'(1)) >= CW'(width_q);

	always_comb begin
		ctl.pix       = drain || in_data.mode || in_data.pixel_in;
		ctl.first_col = (col_q == '0);
		ctl.row_ge1   = (row_q != '0);
		ctl.row_ge2   = (row_q > HW'(1));
		ctl.last_col  = last_col;
		ctl.frame_end = drain && last_col;
		ctl.row       = ero_pkg::POS_W'(CW'(row_q));
		ctl.col       = ero_pkg::POS_W'(CW'(col_q));
	end

	// Configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ero_pkg::REG_IMAGE_WIDTH:  width_q  <= WW'(w_clamp);
				ero_pkg::REG_IMAGE_HEIGHT: height_q <= HW'(h_clamp);
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ero_window.sv
// Window stage: 3x3 window update, buffer write-back, white count and two-deep result output.
module ero_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic                  accept,
	input  ero_pkg::ero_ctl_t     ctl,
	output logic                  in_stall,
	input  logic [1:0]            rd_data,
	output logic                  wr_en,
	output logic [1:0]            wr_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ero_pkg::out_item_t    out_data
);

	ero_pkg::ero_ctl_t ctl_s1;
	logic              s1_v;
	logic [8:0]        window_q;
	logic [ero_pkg::COUNT_W-1:0] white_q;
	logic              out_v_q;
	logic              ex_v_q;
	ero_pkg::out_item_t out_q;
	ero_pkg::out_item_t ex_q;

	logic       top;
	logic       mid;
	logic [8:0] base;
	logic [8:0] win;
	logic       r0_v;
	logic       r1_v;
	logic       p0;
	logic       p1;
	logic [ero_pkg::COUNT_W-1:0] cnt0;
	logic [ero_pkg::COUNT_W-1:0] cnt1;
	ero_pkg::out_item_t r0;
	ero_pkg::out_item_t r1;
	ero_pkg::out_item_t first;
	logic       out_free;
	logic       s1_go;

	// Window: shift in the new column (top, mid, new pixel)
	always_comb begin
		top  = ctl_s1.row_ge2 ? rd_data[1] : 1'b1;
		mid  = ctl_s1.row_ge1 ? rd_data[0] : 1'b1;
		base = ctl_s1.first_col ? ero_pkg::WIN_WHITE : window_q;
		win  = {ctl_s1.pix, mid, top, base[8:3]};
	end

	// Results: centre at col-1, plus the right edge on the last column
	always_comb begin
		r0_v = ctl_s1.row_ge1 && !ctl_s1.first_col;
		r1_v = ctl_s1.row_ge1 && ctl_s1.last_col;
		p0   = &win;
		p1   = &win[8:3];
		cnt0 = (r0_v && p0 && white_q != ero_pkg::WHITE_MAX) ? white_q + 1'b1 : white_q;
		cnt1 = (r1_v && p1 && cnt0 != ero_pkg::WHITE_MAX) ? cnt0 + 1'b1 : cnt0;

		r0.out_pixel   = p0;
		r0.out_row     = ctl_s1.row - 1'b1;
		r0.out_col     = ctl_s1.col - 1'b1;
		r0.white_count = cnt0;
		r0.run_last    = !r1_v;
		r0.frame_done  = ctl_s1.frame_end && !r1_v;

		r1.out_pixel   = p1;
		r1.out_row     = ctl_s1.row - 1'b1;
		r1.out_col     = ctl_s1.col;
		r1.white_count = cnt1;
		r1.run_last    = 1'b1;
		r1.frame_done  = ctl_s1.frame_end;

		first = r0_v ? r0 : r1;
	end

	// Stage advance: the output register must be free and no second result pending
	assign out_free = !out_v_q || !out_stall;
	assign s1_go    = s1_v && !ex_v_q && out_free;
	assign in_stall = s1_v && !s1_go;

	assign wr_en   = s1_go;
	assign wr_data = {mid, ctl_s1.pix};

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v     <= 1'b0;
			window_q <= ero_pkg::WIN_WHITE;
			white_q  <= '0;
			out_v_q  <= 1'b0;
			ex_v_q   <= 1'b0;
		end else begin
			if (accept) begin
				s1_v <= 1'b1;
			end else if (s1_go) begin
				s1_v <= 1'b0;
			end

			if (restart) begin
				window_q <= ero_pkg::WIN_WHITE;
				white_q  <= '0;
			end else if (s1_go) begin
				window_q <= win;
				white_q  <= ctl_s1.frame_end ? '0 : cnt1;
			end

			if (out_free) begin
				if (ex_v_q) begin
					out_v_q <= 1'b1;
					ex_v_q  <= 1'b0;
				end else if (s1_go) begin
					out_v_q <= r0_v || r1_v;
					ex_v_q  <= r0_v && r1_v;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
		if (out_free) begin
			if (ex_v_q) begin
				out_q <= ex_q;
			end else if (s1_go) begin
				out_q <= first;
				ex_q  <= r1;
			end
		end
	end

endmodule

FILE: hdl/binary_erosion_3x3.sv
// Top level of the streaming 3x3 binary erosion block.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data   (mode, pixel_in)
//   out       output     out_valid/out_stall out_data  (pixel, row, col, count, flags)
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// One pixel per clock is accepted while in_stall is low; the last column of a row
// gives two results, and the input stalls while the second result is pending.
// An accepted pixel passes the buffer read and then the window stage.
// Reset clears counters, window and count; the line buffer holds no reset and its
// data is used only where it was written in the current frame.
// An output stall holds the result; the input stalls while the window stage waits.
module binary_erosion_3x3 #(
	parameter int MAX_WIDTH  = ero_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ero_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ero_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ero_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ero_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ero_pkg::out_item_t            out_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic              accept;
	logic [AW-1:0]     rd_addr;
	logic [1:0]        rd_data;
	logic              wr_en;
	logic [1:0]        wr_data;
	ero_pkg::ero_ctl_t ctl;

	ero_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.accept    (accept),
		.rd_addr   (rd_addr),
		.ctl       (ctl)
	);

	ero_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	ero_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.accept    (accept),
		.ctl       (ctl),
		.in_stall  (in_stall),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
